// ----- rtl/core/swm_pkg.sv -----
// Package for the sliding window median core.
// Holds sizes, register index codes and the structs passed between cells.
// No dependencies.
package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;

    localparam int IDX_W  = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int IN_W   = 32;
    localparam int OUT_W  = 33;
    localparam int CFG_W  = 7;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [IDX_W-1:0] age_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic    en;
        logic    full;
        sample_t x;
        count_t  n;
        count_t  n_after;
        age_t    w_m1;
    } swm_bcast_t;

    typedef struct packed {
        logic    rm_seen;
        logic    keep;
        sample_t value;
        age_t    age;
    } swm_fwd_t;

    typedef struct packed {
        sample_t value;
        age_t    age;
        logic    le;
    } swm_bwd_t;

endpackage

// ----- rtl/core/swm_cell.sv -----
// One cell of the sorted window: holds a sample and its age.
// Drops the oldest sample and inserts the new one together with its neighbors.
// Depends on swm_pkg.
module swm_cell
    import swm_pkg::*;
(
    input  logic       aclk,
    input  age_t       idx,
    input  swm_bcast_t bcast,
    input  swm_fwd_t   left_in,
    input  swm_bwd_t   right_in,
    output swm_fwd_t   right_out,
    output swm_bwd_t   left_out,
    output sample_t    value
);

    sample_t value_reg;
    sample_t value_next;
    age_t    age_reg;
    age_t    age_next;

    logic    cell_valid;
    logic    le;
    logic    rm;
    logic    rm_seen;
    sample_t a_value;
    age_t    a_age;
    logic    a_le;
    logic    a_valid;
    logic    keep;

    always_comb begin
        cell_valid = count_t'(idx) < bcast.n;
        le         = $signed(value_reg) <= $signed(bcast.x);
        rm         = bcast.full && cell_valid && (age_reg == bcast.w_m1);
        rm_seen    = left_in.rm_seen | rm;
        a_value    = rm_seen ? right_in.value : value_reg;
        a_age      = rm_seen ? right_in.age : age_reg;
        a_le       = rm_seen ? right_in.le : le;
        a_valid    = count_t'(idx) < bcast.n_after;
        keep       = a_valid && a_le;
        if (keep) begin
            value_next = a_value;
            age_next   = a_age + age_t'(1);
        end else if (left_in.keep) begin
            value_next = bcast.x;
            age_next   = '0;
        end else begin
            value_next = left_in.value;
            age_next   = left_in.age + age_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (bcast.en) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign right_out = '{rm_seen: rm_seen, keep: keep, value: a_value, age: a_age};
    assign left_out  = '{value: value_reg, age: age_reg, le: le};
    assign value     = value_reg;

endmodule

// ----- rtl/core/swm_median.sv -----
// Median pick from the sorted cell row: adds the two middle entries (the middle one twice for an odd window).
// Depends on swm_pkg.
module swm_median
    import swm_pkg::*;
(
    input  sample_t           cell_val [WINDOW_MAX],
    input  count_t            w_eff,
    output logic [OUT_W-1:0]  median_doubled
);

    age_t    hi_idx;
    age_t    lo_idx;
    sample_t hi_val;
    sample_t lo_val;
    logic signed [SAMPLE_WIDTH:0] sum;

    always_comb begin
        hi_idx = age_t'(w_eff >> 1);
        lo_idx = w_eff[0] ? hi_idx : hi_idx - age_t'(1);
        hi_val = cell_val[hi_idx];
        lo_val = cell_val[lo_idx];
        sum    = $signed({hi_val[SAMPLE_WIDTH-1], hi_val})
               + $signed({lo_val[SAMPLE_WIDTH-1], lo_val});
        median_doubled = OUT_W'(sum);
    end

endmodule

// ----- rtl/core/sliding_window_median_core.sv -----
// Sliding window median core: twice the median of the last window_size samples.
// Takes one sample per clock unless a held result waits on a full output queue;
// the window is a row of WINDOW_MAX sorted cells that drop the oldest sample and
// insert the new one in the same cycle. Each result is registered in the cell row,
// then in a two-entry output queue; no result comes until the window has filled
// after reset, restart or a window_size write, which also empties it.
// Depends on swm_pkg, swm_cell and swm_median.
module sliding_window_median_core
    import swm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [IN_W-1:0] s_sample,
    input  logic                s_restart,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [OUT_W-1:0] m_median_doubled,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [CFG_W-1:0] win_size_reg;
    count_t           fill_reg;
    count_t           fill_next;
    logic             mid_valid_reg;
    logic             mid_valid_next;
    logic [OUT_W-1:0] fifo_mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    logic             cfg_wr;
    logic             accept;
    count_t           w_eff;
    count_t           n;
    logic             full;
    logic             produce;
    logic             push;
    logic             pop;
    logic [OUT_W-1:0] median;
    swm_bcast_t       bcast;

    swm_fwd_t         fwd [WINDOW_MAX+1];
    swm_bwd_t         bwd [WINDOW_MAX+1];
    sample_t          cell_val [WINDOW_MAX];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_WINDOW_SIZE);
    assign prdata = (paddr[2:2] == REG_WINDOW_SIZE) ? DATA_W'(win_size_reg) : '0;

    always_comb begin
        if (win_size_reg == '0) begin
            w_eff = count_t'(1);
        end else if (CNT_W'(win_size_reg) > count_t'(WINDOW_MAX)) begin
            w_eff = count_t'(WINDOW_MAX);
        end else begin
            w_eff = count_t'(win_size_reg);
        end
        accept    = s_valid && s_ready;
        n         = s_restart ? '0 : fill_reg;
        full      = (n == w_eff);
        fill_next = full ? w_eff : n + count_t'(1);
        produce   = (fill_next == w_eff);
        bcast.en      = accept;
        bcast.full    = full;
        bcast.x       = sample_t'(s_sample[SAMPLE_WIDTH-1:0]);
        bcast.n       = n;
        bcast.n_after = full ? w_eff - count_t'(1) : n;
        bcast.w_m1    = age_t'(w_eff - count_t'(1));
    end

    assign s_ready = !mid_valid_reg || (cnt_reg != 2'd2);
    assign push    = mid_valid_reg && (cnt_reg != 2'd2);
    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_median_doubled = fifo_mem_reg[rd_ptr_reg];

    assign mid_valid_next = (accept && produce) || (mid_valid_reg && !push);
    assign cnt_next       = cnt_reg + {1'b0, push} - {1'b0, pop};

    assign fwd[0]          = '{rm_seen: 1'b0, keep: 1'b1, value: '0, age: '0};
    assign bwd[WINDOW_MAX] = '{value: '0, age: '0, le: 1'b0};

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        swm_cell u_cell (
            .aclk      (aclk),
            .idx       (age_t'(i)),
            .bcast     (bcast),
            .left_in   (fwd[i]),
            .right_in  (bwd[i+1]),
            .right_out (fwd[i+1]),
            .left_out  (bwd[i]),
            .value     (cell_val[i])
        );
    end

    swm_median u_median (
        .cell_val       (cell_val),
        .w_eff          (w_eff),
        .median_doubled (median)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg  <= WINDOW_SIZE_RESET;
            fill_reg      <= '0;
            mid_valid_reg <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr) begin
                win_size_reg <= pwdata[CFG_W-1:0];
                fill_reg     <= '0;
            end else if (accept) begin
                fill_reg <= fill_next;
            end
            mid_valid_reg <= mid_valid_next;
            cnt_reg       <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= median;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= w_eff)
        else $error("fill count exceeds window");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && (cnt_reg == 2'd2)))
        else $error("push into full output queue");

    a_restart_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_restart && (w_eff == count_t'(1))) |=> mid_valid_reg)
        else $error("single-sample window gave no result");
`endif

endmodule

// ----- test/swm_median_checker.sv -----
// Checker for the sliding window median core: watches the sample, result and register ports,
// predicts twice the window median for every sample transaction that fills the window and compares the results.
// Depends on swm_pkg.
module swm_median_checker
    import swm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_sample,
    input  logic                    s_restart,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [OUT_W-1:0] m_median_doubled,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    input  logic                    pready,
    output int                      failures,
    output int                      outstanding,
    output int                      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [OUT_W-1:0] median_t;

    logic [CFG_W-1:0] win_size;
    sample_t          history [WINDOW_MAX];
    sample_t          ordered [$];
    median_t          pending_medians [$];
    median_t          want;
    int unsigned      filled;
    int unsigned      oldest;
    int               fail_cnt;
    int               check_cnt;

    function automatic void clear_window();
        filled = 0;
        oldest = 0;
        ordered.delete();
    endfunction

    function automatic int unsigned active_len();
        if (win_size == 0) return 1;
        if (win_size > WINDOW_MAX) return WINDOW_MAX;
        return win_size;
    endfunction

    function automatic void place(sample_t x);
        int k;
        k = 0;
        while (k < ordered.size() && ordered[k] <= x) k++;
        ordered.insert(k, x);
    endfunction

    function automatic void take_sample(sample_t x, logic restart);
        int unsigned w;
        int unsigned p;
        int          k;
        median_t     lo;
        median_t     hi;
        w = active_len();
        if (restart || filled > w) clear_window();
        if (filled < w) begin
            history[filled] = x;
            place(x);
            filled++;
            oldest = 0;
        end else begin
            p = oldest % w;
            // drop exactly one copy of the leaving sample
            k = 0;
            while (k < ordered.size() && ordered[k] != history[p]) k++;
            if (k < ordered.size()) ordered.delete(k);
            history[p] = x;
            place(x);
            oldest = (p + 1) % w;
        end
        if (filled == w) begin
            lo = ordered[(w - 1) / 2];
            hi = ordered[w / 2];
            pending_medians.insert(pending_medians.size(), lo + hi);
        end
    endfunction

    function automatic void flag(string what, median_t expected, median_t actual);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("[%0t] median mismatch (%s): expected %0d, got %0d",
                     $time, what, expected, actual);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_size = WINDOW_SIZE_RESET;
            clear_window();
            pending_medians.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_WINDOW_SIZE) begin
                win_size = pwdata[CFG_W-1:0];
                clear_window();
            end
            if (s_valid && s_ready) take_sample(s_sample[SAMPLE_WIDTH-1:0], s_restart);
            if (m_valid && m_ready) begin
                check_cnt++;
                if (pending_medians.size() == 0) begin
                    flag("no sample waiting", 'x, m_median_doubled);
                end else begin
                    want = pending_medians.pop_front();
                    if (m_median_doubled !== want) flag("value", want, m_median_doubled);
                end
            end
        end
        failures    <= fail_cnt;
        outstanding <= pending_medians.size();
        checked     <= check_cnt;
    end

endmodule

// ----- test/sliding_window_median_core_test.sv -----
// Top of the sliding window median testbench: clock, reset, sample and register stimulus,
// random idling on both channels and the final verdict.
// Depends on swm_pkg, sliding_window_median_core and swm_median_checker.
module sliding_window_median_core_test
    import swm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GAP        = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASE   = 8;
    localparam int UNMAPPED_PHASE = 3;
    localparam int N_DIRECTED     = 20;
    localparam int N_PHASES       = 12;

    localparam logic [ADDR_W-1:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = ADDR_WINDOW_SIZE + 3'd4;

    localparam sample_t S_MAX = 32'sh7fffffff;
    localparam sample_t S_MIN = 32'sh80000000;
    localparam logic [N_DIRECTED-1:0] DIR_RESTART = (20'd1 << 13) | (20'd1 << 15);

    sample_t          dir_samples [N_DIRECTED] = '{0, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX,
                                                   S_MAX, 5, 5, -3, 5, 5, 7, 8, 9, 1, -1, -1, 2};
    logic [CFG_W-1:0] phase_sizes [N_PHASES] = '{2, 1, 0, 5, 64, 127, 4, 100, 9, 7, 6, 3};

    logic                    aclk             = 1'b0;
    logic                    aresetn          = 1'b0;
    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic signed [IN_W-1:0]  s_sample         = '0;
    logic                    s_restart        = 1'b0;
    logic                    m_valid;
    logic                    m_ready          = 1'b0;
    logic signed [OUT_W-1:0] m_median_doubled;
    logic                    psel             = 1'b0;
    logic                    penable          = 1'b0;
    logic                    pwrite           = 1'b0;
    logic [ADDR_W-1:0]       paddr            = '0;
    logic [DATA_W-1:0]       pwdata           = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    int   failures;
    int   outstanding;
    int   checked;
    int   cycles   = 0;
    int   sent     = 0;
    int   settings = 0;
    logic steady   = 1'b0;
    logic hold_req = 1'b0;

    sliding_window_median_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_median_doubled (m_median_doubled),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    swm_median_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_median_doubled (m_median_doubled),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .failures         (failures),
        .outstanding      (outstanding),
        .checked          (checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d medians outstanding", cycles, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3, 4: return sample_t'($urandom_range(0, 8)) - 4;
            default: return sample_t'($urandom());
        endcase
    endfunction

    task automatic send_item(input sample_t smp, input logic rst);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= smp;
        s_restart <= rst;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // drop valid, wait out every pending median and the tail of the pipeline
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int stall;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        int               eff;
        int               n_items;
        logic             rst;
        logic [CFG_W-1:0] size;
        logic [DATA_W-1:0] word;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) send_item(dir_samples[i], DIR_RESTART[i]);
        settle();

        // hold the result side while samples keep coming
        word = $urandom();
        word[CFG_W-1:0] = 7'd4;
        reg_write(ADDR_WINDOW_SIZE, word);
        settings++;
        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_item(pick_sample(), 1'b0);
        steady = 1'b0;
        settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            size = (ph == RANDOM_PHASE) ? CFG_W'($urandom_range(1, WINDOW_MAX)) : phase_sizes[ph];
            word = $urandom();
            word[CFG_W-1:0] = size;
            reg_write(ADDR_WINDOW_SIZE, word);
            settings++;
            eff     = (size == 0) ? 1 : (size > WINDOW_MAX) ? WINDOW_MAX : size;
            n_items = (eff > 16) ? 130 : 70;
            steady  = (ph % 4 == 3);
            for (int k = 0; k < n_items; k++) begin
                if (ph == UNMAPPED_PHASE && k == n_items / 2) begin
                    settle();
                    reg_write(ADDR_UNMAPPED, $urandom());
                end
                rst = (eff <= 16) ? ($urandom_range(0, 99) < 6) : (k == n_items * 2 / 3);
                send_item(pick_sample(), rst);
            end
            settle();
        end
        steady = 1'b0;

        $display("Sent %0d samples over %0d window settings (sizes 0 to 127, restarts, a long",
                 sent, settings);
        $display("output stall); %0d medians compared, %0d mismatches", checked, failures);
        if (failures == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
